// ----- rtl/pimr_pkg.sv -----
package pimr_pkg;

    localparam int CRW = 33;
    localparam int WTW = 68;
    localparam int ACW = 102;
    localparam int SMW = 70;
    localparam int SCW = 77;
    localparam int CNW = 11;

    localparam logic [1:0] REQ_VERTEX   = 2'd0;
    localparam logic [1:0] REQ_TRIANGLE = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    localparam logic [1:0] VERDICT_INSIDE  = 2'd0;
    localparam logic [1:0] VERDICT_OUTSIDE = 2'd1;
    localparam logic [1:0] VERDICT_UNSURE  = 2'd2;

    localparam logic [3:0] OP_AX = 4'd0;
    localparam logic [3:0] OP_AY = 4'd1;
    localparam logic [3:0] OP_AZ = 4'd2;
    localparam logic [3:0] OP_BX = 4'd3;
    localparam logic [3:0] OP_BY = 4'd4;
    localparam logic [3:0] OP_BZ = 4'd5;
    localparam logic [3:0] OP_CX = 4'd6;
    localparam logic [3:0] OP_CY = 4'd7;
    localparam logic [3:0] OP_CZ = 4'd8;
    localparam logic [3:0] OP_W0 = 4'd9;
    localparam logic [3:0] OP_W1 = 4'd10;
    localparam logic [3:0] OP_W2 = 4'd11;
    localparam logic [3:0] OP_E1 = 4'd12;
    localparam logic [3:0] OP_E2 = 4'd13;

    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_W0   = 3'd1;
    localparam logic [2:0] DST_W1   = 3'd2;
    localparam logic [2:0] DST_W2   = 3'd3;
    localparam logic [2:0] DST_E1   = 3'd4;
    localparam logic [2:0] DST_E2   = 3'd5;
    localparam logic [2:0] DST_V0   = 3'd6;
    localparam logic [2:0] DST_D    = 3'd7;

    localparam logic [3:0] PROD_LAST_V0 = 4'd12;
    localparam logic [3:0] PROD_LAST    = 4'd15;

    typedef struct packed {
        logic [3:0] asel;
        logic [3:0] bsel;
        logic       sub;
        logic       first;
        logic [2:0] dst;
    } prod_t;

    typedef struct packed {
        logic       wr_vtx;
        logic       wr_tri;
        logic       load_pt;
        logic       rd_tri;
        logic       rd_v;
        logic [1:0] rd_corner;
        logic       cap;
        logic [1:0] cap_corner;
        logic       mac_start;
        prod_t      prod;
        logic       store;
        logic       negate;
        logic       sum;
        logic       cmp;
        logic [1:0] cmp_k;
        logic       clr_flags;
        logic       clr_cnt;
        logic       inc_cnt;
        logic       load_out;
        logic [1:0] out_verdict;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic mac_done;
        logic s_zero;
        logic skip;
        logic edge_hit;
        logic d_pos;
        logic cnt_odd;
    } dp_stat_t;

    function automatic prod_t prod_step(input logic [3:0] j);
        prod_t p;
        p = '{asel: OP_AX, bsel: OP_AX, sub: 1'b0, first: 1'b0, dst: DST_NONE};
        unique case (j)
            4'd0:  p = '{asel: OP_BY, bsel: OP_CZ, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd1:  p = '{asel: OP_BZ, bsel: OP_CY, sub: 1'b1, first: 1'b0, dst: DST_W0};
            4'd2:  p = '{asel: OP_CY, bsel: OP_AZ, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd3:  p = '{asel: OP_CZ, bsel: OP_AY, sub: 1'b1, first: 1'b0, dst: DST_W1};
            4'd4:  p = '{asel: OP_AY, bsel: OP_BZ, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd5:  p = '{asel: OP_AZ, bsel: OP_BY, sub: 1'b1, first: 1'b0, dst: DST_W2};
            4'd6:  p = '{asel: OP_BZ, bsel: OP_CX, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd7:  p = '{asel: OP_BX, bsel: OP_CZ, sub: 1'b1, first: 1'b0, dst: DST_E1};
            4'd8:  p = '{asel: OP_BX, bsel: OP_CY, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd9:  p = '{asel: OP_BY, bsel: OP_CX, sub: 1'b1, first: 1'b0, dst: DST_E2};
            4'd10: p = '{asel: OP_W0, bsel: OP_AX, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd11: p = '{asel: OP_E1, bsel: OP_AY, sub: 1'b0, first: 1'b0, dst: DST_NONE};
            4'd12: p = '{asel: OP_E2, bsel: OP_AZ, sub: 1'b0, first: 1'b0, dst: DST_V0};
            4'd13: p = '{asel: OP_W0, bsel: OP_AX, sub: 1'b0, first: 1'b1, dst: DST_NONE};
            4'd14: p = '{asel: OP_W1, bsel: OP_BX, sub: 1'b0, first: 1'b0, dst: DST_NONE};
            4'd15: p = '{asel: OP_W2, bsel: OP_CX, sub: 1'b0, first: 1'b0, dst: DST_D};
            default: p = '{asel: OP_AX, bsel: OP_AX, sub: 1'b0, first: 1'b0, dst: DST_NONE};
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/pimr_mac.sv -----
module pimr_mac
    import pimr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  first,
    input  logic                  sub,
    input  logic signed [WTW-1:0] a,
    input  logic signed [CRW-1:0] b,
    output logic signed [ACW-1:0] acc,
    output logic                  busy,
    output logic                  done
);

    logic signed [ACW-1:0] acc_reg, acc_next;
    logic signed [ACW-1:0] a_sh_reg, a_sh_next;
    logic [CRW-1:0]        b_sh_reg, b_sh_next;
    logic [5:0]            bit_reg, bit_next;
    logic                  sub_reg, sub_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  neg;

    always_comb
    begin
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        bit_next  = bit_reg;
        sub_next  = sub_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg       = (bit_reg == 6'(CRW - 1)) ^ sub_reg;
        if (start)
        begin
            a_sh_next = ACW'(a);
            b_sh_next = b;
            bit_next  = 6'd0;
            sub_next  = sub;
            busy_next = 1'b1;
            if (first)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_next = neg ? (acc_reg - a_sh_reg) : (acc_reg + a_sh_reg);
            end
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            bit_next  = bit_reg + 6'd1;
            if (bit_reg == 6'(CRW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        sub_reg  <= sub_next;
    end

    assign acc  = acc_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- rtl/pimr_datapath.sv -----
module pimr_datapath
    import pimr_pkg::*;
#(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024,
    parameter int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    parameter int TA = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [TA-1:0]      tri_idx,
    input  logic [9:0]         slot,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [9:0]         corner_a,
    input  logic [9:0]         corner_b,
    input  logic [9:0]         corner_c,
    output dp_stat_t           stat,
    output logic [1:0]         verdict,
    output logic [CNW-1:0]     crossings
);

    logic [95:0] vtx_mem [MAX_VERTICES];
    logic [29:0] tri_mem [MAX_TRIANGLES];

    logic [95:0]           vtx_q_reg;
    logic                  vtx_ok_reg;
    logic [29:0]           tri_q_reg;
    logic signed [31:0]    p_reg [3];
    logic signed [CRW-1:0] rel_reg [3][3];
    logic signed [CRW-1:0] cap_rel [3];
    logic signed [WTW-1:0] w_reg [3];
    logic signed [WTW-1:0] e_reg [2];
    logic signed [SMW-1:0] as_reg;
    logic                  v0_pos_reg;
    logic                  s_zero_reg;
    logic                  skip_reg;
    logic                  edge_reg;
    logic                  d_pos_reg;
    logic [CNW-1:0]        cnt_reg;
    logic [1:0]            verdict_reg;
    logic [CNW-1:0]        crossings_reg;

    logic                  slot_vtx_ok;
    logic                  slot_tri_ok;
    logic [9:0]            rd_corner;
    logic                  corner_ok;
    logic signed [WTW-1:0] a_op;
    logic signed [CRW-1:0] b_op;
    logic signed [ACW-1:0] acc;
    logic                  acc_pos;
    logic                  mac_busy;
    logic                  mac_done;
    logic signed [SMW-1:0] s_sum;
    logic signed [WTW-1:0] wk;
    logic signed [SCW-1:0] wk_ext;
    logic signed [SCW-1:0] sc;
    logic signed [SCW-1:0] as_ext;

    assign slot_vtx_ok = {22'd0, slot} < 32'(MAX_VERTICES);
    assign slot_tri_ok = {22'd0, slot} < 32'(MAX_TRIANGLES);

    always_comb
    begin
        unique case (cmd.rd_corner)
            2'd1:    rd_corner = tri_q_reg[19:10];
            2'd2:    rd_corner = tri_q_reg[29:20];
            default: rd_corner = tri_q_reg[9:0];
        endcase
    end

    assign corner_ok = {22'd0, rd_corner} < 32'(MAX_VERTICES);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_vtx && slot_vtx_ok)
        begin
            vtx_mem[VA'(slot)] <= {coord_z, coord_y, coord_x};
        end
        if (cmd.wr_tri && slot_tri_ok)
        begin
            tri_mem[TA'(slot)] <= {corner_c, corner_b, corner_a};
        end
        if (cmd.rd_tri)
        begin
            tri_q_reg <= tri_mem[tri_idx];
        end
        if (cmd.rd_v)
        begin
            vtx_q_reg  <= vtx_mem[VA'(rd_corner)];
            vtx_ok_reg <= corner_ok;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cap_rel[k] = vtx_ok_reg
                ? (CRW'($signed(vtx_q_reg[32*k +: 32])) - CRW'(p_reg[k]))
                : -CRW'(p_reg[k]);
        end
    end

    always_comb
    begin
        unique case (cmd.prod.asel)
            OP_AX:   a_op = WTW'(rel_reg[0][0]);
            OP_AY:   a_op = WTW'(rel_reg[0][1]);
            OP_AZ:   a_op = WTW'(rel_reg[0][2]);
            OP_BX:   a_op = WTW'(rel_reg[1][0]);
            OP_BY:   a_op = WTW'(rel_reg[1][1]);
            OP_BZ:   a_op = WTW'(rel_reg[1][2]);
            OP_CX:   a_op = WTW'(rel_reg[2][0]);
            OP_CY:   a_op = WTW'(rel_reg[2][1]);
            OP_CZ:   a_op = WTW'(rel_reg[2][2]);
            OP_W0:   a_op = w_reg[0];
            OP_W1:   a_op = w_reg[1];
            OP_W2:   a_op = w_reg[2];
            OP_E1:   a_op = e_reg[0];
            OP_E2:   a_op = e_reg[1];
            default: a_op = '0;
        endcase
        unique case (cmd.prod.bsel)
            OP_AX:   b_op = rel_reg[0][0];
            OP_AY:   b_op = rel_reg[0][1];
            OP_AZ:   b_op = rel_reg[0][2];
            OP_BX:   b_op = rel_reg[1][0];
            OP_BY:   b_op = rel_reg[1][1];
            OP_BZ:   b_op = rel_reg[1][2];
            OP_CX:   b_op = rel_reg[2][0];
            OP_CY:   b_op = rel_reg[2][1];
            OP_CZ:   b_op = rel_reg[2][2];
            default: b_op = '0;
        endcase
    end

    pimr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mac_start),
        .first (cmd.prod.first),
        .sub   (cmd.prod.sub),
        .a     (a_op),
        .b     (b_op),
        .acc   (acc),
        .busy  (mac_busy),
        .done  (mac_done)
    );

    assign acc_pos = !acc[ACW-1] && (acc != '0);
    assign s_sum   = SMW'(w_reg[0]) + SMW'(w_reg[1]) + SMW'(w_reg[2]);

    always_comb
    begin
        unique case (cmd.cmp_k)
            2'd1:    wk = w_reg[1];
            2'd2:    wk = w_reg[2];
            default: wk = w_reg[0];
        endcase
        wk_ext = SCW'(wk);
        sc     = (wk_ext <<< 6) + (wk_ext <<< 5) + (wk_ext <<< 2);
        as_ext = SCW'(as_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pt)
        begin
            p_reg[0] <= coord_x;
            p_reg[1] <= coord_y;
            p_reg[2] <= coord_z;
        end
        if (cmd.cap)
        begin
            unique case (cmd.cap_corner)
                2'd0:    rel_reg[0] <= cap_rel;
                2'd1:    rel_reg[1] <= cap_rel;
                2'd2:    rel_reg[2] <= cap_rel;
                default: ;
            endcase
        end
        if (cmd.store)
        begin
            unique case (cmd.prod.dst)
                DST_W0:  w_reg[0] <= acc[WTW-1:0];
                DST_W1:  w_reg[1] <= acc[WTW-1:0];
                DST_W2:  w_reg[2] <= acc[WTW-1:0];
                DST_E1:  e_reg[0] <= acc[WTW-1:0];
                DST_E2:  e_reg[1] <= acc[WTW-1:0];
                DST_V0:  v0_pos_reg <= acc_pos;
                DST_D:   d_pos_reg <= acc_pos;
                default: ;
            endcase
        end
        if (cmd.negate && !v0_pos_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w_reg[k] <= -w_reg[k];
            end
        end
        if (cmd.sum)
        begin
            s_zero_reg <= (s_sum == '0);
            as_reg     <= s_sum[SMW-1] ? -s_sum : s_sum;
        end
        if (cmd.load_out)
        begin
            verdict_reg   <= cmd.out_verdict;
            crossings_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
            edge_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_flags)
            begin
                skip_reg <= 1'b0;
                edge_reg <= 1'b0;
            end
            else if (cmd.cmp)
            begin
                skip_reg <= skip_reg || (sc < -as_ext);
                edge_reg <= edge_reg || (sc < as_ext);
            end
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.inc_cnt)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
            end
        end
    end

    assign stat.mac_busy = mac_busy;
    assign stat.mac_done = mac_done;
    assign stat.s_zero   = s_zero_reg;
    assign stat.skip     = skip_reg;
    assign stat.edge_hit = edge_reg;
    assign stat.d_pos    = d_pos_reg;
    assign stat.cnt_odd  = cnt_reg[0];
    assign verdict       = verdict_reg;
    assign crossings     = crossings_reg;

endmodule

// ----- rtl/pimr_ctrl.sv -----
module pimr_ctrl
    import pimr_pkg::*;
#(
    parameter int MAX_TRIANGLES = 1024,
    parameter int TA = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
    parameter int TW = $clog2(MAX_TRIANGLES + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      req_type,
    output logic            out_valid,
    input  logic            out_stall,
    input  logic            cfg_wr_en,
    input  logic [CNW-1:0]  cfg_wr_data,
    input  dp_stat_t        stat,
    output ctrl_cmd_t       cmd,
    output logic [TA-1:0]   tri_idx
);

    localparam int NW = (TW > CNW) ? TW : CNW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_TRI   = 4'd1;
    localparam logic [3:0] S_RD_A     = 4'd2;
    localparam logic [3:0] S_RD_B     = 4'd3;
    localparam logic [3:0] S_RD_C     = 4'd4;
    localparam logic [3:0] S_CAP_C    = 4'd5;
    localparam logic [3:0] S_MUL_GO   = 4'd6;
    localparam logic [3:0] S_MUL_WAIT = 4'd7;
    localparam logic [3:0] S_NEG      = 4'd8;
    localparam logic [3:0] S_SUM      = 4'd9;
    localparam logic [3:0] S_CHK      = 4'd10;
    localparam logic [3:0] S_CMP      = 4'd11;
    localparam logic [3:0] S_JUDGE    = 4'd12;
    localparam logic [3:0] S_DECIDE   = 4'd13;
    localparam logic [3:0] S_NEXT     = 4'd14;
    localparam logic [3:0] S_FINISH   = 4'd15;

    logic [3:0]     state_reg, state_next;
    logic [TW-1:0]  t_reg, t_next;
    logic [TW-1:0]  n_reg, n_next;
    logic [3:0]     j_reg, j_next;
    logic [1:0]     k_reg, k_next;
    logic           unsure_reg, unsure_next;
    logic [CNW-1:0] count_reg;
    logic           out_valid_reg, out_valid_next;

    logic [NW-1:0]  count_ext;
    logic [TW-1:0]  n_lim;
    logic           accept;
    logic           out_free;

    assign count_ext = NW'(count_reg);
    assign n_lim     = (count_ext > NW'(MAX_TRIANGLES)) ? TW'(MAX_TRIANGLES) : TW'(count_ext);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        unsure_next    = unsure_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.prod       = prod_step(j_reg);
        cmd.cmp_k      = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (req_type == REQ_VERTEX)
                    begin
                        cmd.wr_vtx = 1'b1;
                    end
                    else if (req_type == REQ_TRIANGLE)
                    begin
                        cmd.wr_tri = 1'b1;
                    end
                    else if (req_type == REQ_QUERY)
                    begin
                        cmd.load_pt = 1'b1;
                        cmd.clr_cnt = 1'b1;
                        t_next      = '0;
                        n_next      = n_lim;
                        unsure_next = 1'b0;
                        state_next  = (n_lim == '0) ? S_FINISH : S_RD_TRI;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD_TRI:
            begin
                cmd.rd_tri = 1'b1;
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                cmd.rd_v      = 1'b1;
                cmd.rd_corner = 2'd0;
                state_next    = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_v       = 1'b1;
                cmd.rd_corner  = 2'd1;
                cmd.cap        = 1'b1;
                cmd.cap_corner = 2'd0;
                state_next     = S_RD_C;
            end
            S_RD_C:
            begin
                cmd.rd_v       = 1'b1;
                cmd.rd_corner  = 2'd2;
                cmd.cap        = 1'b1;
                cmd.cap_corner = 2'd1;
                state_next     = S_CAP_C;
            end
            S_CAP_C:
            begin
                cmd.cap        = 1'b1;
                cmd.cap_corner = 2'd2;
                cmd.clr_flags  = 1'b1;
                j_next         = '0;
                state_next     = S_MUL_GO;
            end
            S_MUL_GO:
            begin
                cmd.mac_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (stat.mac_done)
                begin
                    cmd.store = 1'b1;
                    j_next    = j_reg + 4'd1;
                    priority if (j_reg == PROD_LAST_V0)
                    begin
                        state_next = S_NEG;
                    end
                    else if (j_reg == PROD_LAST)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_MUL_GO;
                    end
                end
            end
            S_NEG:
            begin
                cmd.negate = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                k_next = 2'd0;
                if (stat.s_zero)
                begin
                    unsure_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                k_next  = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                priority if (stat.skip)
                begin
                    state_next = S_NEXT;
                end
                else if (stat.edge_hit)
                begin
                    unsure_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL_GO;
                end
            end
            S_DECIDE:
            begin
                cmd.inc_cnt = stat.d_pos;
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                t_next = t_reg + TW'(1);
                if ((t_reg + TW'(1)) == n_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RD_TRI;
                end
            end
            S_FINISH:
            begin
                if (unsure_reg)
                begin
                    cmd.out_verdict = VERDICT_UNSURE;
                end
                else
                begin
                    cmd.out_verdict = stat.cnt_odd ? VERDICT_INSIDE : VERDICT_OUTSIDE;
                end
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            unsure_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            unsure_reg    <= unsure_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign tri_idx   = TA'(t_reg);

    a_mac_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_start |-> !stat.mac_busy)
        else $error("multiply started while the shared unit is busy");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_FINISH) |-> (t_reg < n_reg))
        else $error("triangle index past the walk length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over an untaken result");

    a_store_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> $past(state_reg) == S_MUL_WAIT || $past(state_reg) == S_MUL_GO)
        else $error("product stored outside a multiply step");

endmodule

// ----- rtl/point_in_mesh_ray_parity_core.sv -----
// Point-in-mesh test by ray crossing parity. Write vertices (req_type 0) and
// triangles (req_type 1) first, set the triangle count through cfg_wr_en and
// cfg_wr_data, then send a query point (req_type 2); each query gives one
// result, writes give none. A write leaves in_stall low. A query walks the
// triangles from slot 0; up to sixteen products of a triangle (thirteen for
// one that the ray misses) go through one shared bit-serial multiplier, and
// an unsure verdict ends the walk early. The stores come up undefined and
// need no clearing pass.
module point_in_mesh_ray_parity_core
    import pimr_pkg::*;
#(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [9:0]         slot,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [9:0]         corner_a,
    input  logic [9:0]         corner_b,
    input  logic [9:0]         corner_c,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         verdict,
    output logic [CNW-1:0]     crossings,
    input  logic               cfg_wr_en,
    input  logic [CNW-1:0]     cfg_wr_data
);

    localparam int TA = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    ctrl_cmd_t     cmd;
    dp_stat_t      stat;
    logic [TA-1:0] tri_idx;

    pimr_ctrl #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .cmd         (cmd),
        .tri_idx     (tri_idx)
    );

    pimr_datapath #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .tri_idx   (tri_idx),
        .slot      (slot),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .stat      (stat),
        .verdict   (verdict),
        .crossings (crossings)
    );

endmodule

// ----- tb/sv/point_in_mesh_ray_parity_core_tb.sv -----
`timescale 1ns / 1ps

module point_in_mesh_ray_parity_core_tb;
    import pimr_pkg::*;

    localparam int VTX_DEPTH = 1024;
    localparam int TRI_DEPTH = 1024;
    localparam int U = 65536;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    typedef logic signed [135:0] big_t;

    typedef struct {
        logic [1:0]         req;
        logic [9:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [9:0]         ca;
        logic [9:0]         cb;
        logic [9:0]         cc;
    } mesh_req_t;

    typedef struct {
        logic [1:0]     verdict;
        logic [CNW-1:0] crossings;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = '0;
    logic [9:0]         slot = '0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic [9:0]         corner_a = '0;
    logic [9:0]         corner_b = '0;
    logic [9:0]         corner_c = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         verdict;
    logic [CNW-1:0]     crossings;
    logic               cfg_wr_en = 1'b0;
    logic [CNW-1:0]     cfg_wr_data = '0;

    mesh_req_t pending_q[$];
    verdict_t  verdict_q[$];
    int        known_vtx[$];

    logic signed [31:0] vtx_x[VTX_DEPTH];
    logic signed [31:0] vtx_y[VTX_DEPTH];
    logic signed [31:0] vtx_z[VTX_DEPTH];
    logic [9:0]         tri_a[TRI_DEPTH];
    logic [9:0]         tri_b[TRI_DEPTH];
    logic [9:0]         tri_c[TRI_DEPTH];
    int                 walk_count = 0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int n_writes = 0;
    int n_queries = 0;
    int n_checked = 0;

    point_in_mesh_ray_parity_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .slot        (slot),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .corner_a    (corner_a),
        .corner_b    (corner_b),
        .corner_c    (corner_c),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict),
        .crossings   (crossings),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic verdict_t ray_parity(input logic signed [31:0] px_in,
                                            input logic signed [31:0] py_in,
                                            input logic signed [31:0] pz_in);
        verdict_t r;
        big_t px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
        big_t w0, w1, w2, v0, s, as, d;
        int n, cnt;
        bit skip, edge_hit;
        px = big_t'(px_in);
        py = big_t'(py_in);
        pz = big_t'(pz_in);
        cnt = 0;
        n = (walk_count > TRI_DEPTH) ? TRI_DEPTH : walk_count;
        for (int t = 0; t < n; t++)
        begin
            ax = big_t'(vtx_x[tri_a[t]]);
            ay = big_t'(vtx_y[tri_a[t]]);
            az = big_t'(vtx_z[tri_a[t]]);
            bx = big_t'(vtx_x[tri_b[t]]);
            by = big_t'(vtx_y[tri_b[t]]);
            bz = big_t'(vtx_z[tri_b[t]]);
            cx = big_t'(vtx_x[tri_c[t]]);
            cy = big_t'(vtx_y[tri_c[t]]);
            cz = big_t'(vtx_z[tri_c[t]]);
            ax = ax - px; ay = ay - py; az = az - pz;
            bx = bx - px; by = by - py; bz = bz - pz;
            cx = cx - px; cy = cy - py; cz = cz - pz;
            w0 = by * cz - bz * cy;
            w1 = cy * az - cz * ay;
            w2 = ay * bz - az * by;
            v0 = ax * w0 + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
            if (v0 <= 0)
            begin
                w0 = -w0;
                w1 = -w1;
                w2 = -w2;
            end
            s = w0 + w1 + w2;
            if (s == 0)
            begin
                r.verdict = VERDICT_UNSURE;
                r.crossings = CNW'(cnt);
                return r;
            end
            as = (s < 0) ? -s : s;
            skip = (w0 * 100 < -as) || (w1 * 100 < -as) || (w2 * 100 < -as);
            edge_hit = (w0 * 100 < as) || (w1 * 100 < as) || (w2 * 100 < as);
            if (skip)
                continue;
            if (edge_hit)
            begin
                r.verdict = VERDICT_UNSURE;
                r.crossings = CNW'(cnt);
                return r;
            end
            d = w0 * ax + w1 * bx + w2 * cx;
            if (d > 0)
                cnt++;
        end
        r.verdict = cnt[0] ? VERDICT_INSIDE : VERDICT_OUTSIDE;
        r.crossings = CNW'(cnt);
        return r;
    endfunction

    task automatic apply_transfer();
        case (req_type)
            REQ_VERTEX:
            begin
                vtx_x[slot] = coord_x;
                vtx_y[slot] = coord_y;
                vtx_z[slot] = coord_z;
            end
            REQ_TRIANGLE:
            begin
                tri_a[slot] = corner_a;
                tri_b[slot] = corner_b;
                tri_c[slot] = corner_c;
            end
            REQ_QUERY:
                verdict_q.push_back(ray_parity(coord_x, coord_y, coord_z));
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        mesh_req_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_transfer();
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = pending_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= it.req;
                    slot     <= it.slot;
                    coord_x  <= it.x;
                    coord_y  <= it.y;
                    coord_z  <= it.z;
                    corner_a <= it.ca;
                    corner_b <= it.cb;
                    corner_c <= it.cc;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : check_blk
        verdict_t w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    report("unexpected result, verdict", verdict, -1);
                end
                else
                begin
                    w = verdict_q.pop_front();
                    n_checked++;
                    if (verdict !== w.verdict)
                        report("verdict", verdict, w.verdict);
                    if (crossings !== w.crossings)
                        report("crossings", crossings, w.crossings);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic queue_raw(input logic [1:0] rq, input int sl, input int x, input int y,
                             input int z, input int a, input int b, input int c);
        mesh_req_t it;
        it.req = rq;
        it.slot = 10'(sl);
        it.x = x;
        it.y = y;
        it.z = z;
        it.ca = 10'(a);
        it.cb = 10'(b);
        it.cc = 10'(c);
        pending_q.push_back(it);
        if (rq == REQ_QUERY)
            n_queries++;
        else if (rq != REQ_UNUSED)
            n_writes++;
    endtask

    task automatic queue_vertex(input int sl, input int x, input int y, input int z);
        queue_raw(REQ_VERTEX, sl, x, y, z, $urandom, $urandom, $urandom);
        known_vtx.push_back(sl);
    endtask

    task automatic queue_triangle(input int sl, input int a, input int b, input int c);
        queue_raw(REQ_TRIANGLE, sl, $urandom, $urandom, $urandom, a, b, c);
    endtask

    task automatic queue_query(input int x, input int y, input int z);
        queue_raw(REQ_QUERY, $urandom, x, y, z, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_walk_count(input int v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CNW'(v);
        walk_count = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_vtx();
        return known_vtx[$urandom_range(known_vtx.size() - 1)];
    endfunction

    task automatic mesh_scene(input bit full_range);
        int base, extra, cnt, sc, ox, oy, oz, q;
        extra = $urandom_range(0, 2);
        cnt = ($urandom_range(99) < 80) ? 4 + extra : $urandom_range(0, 4 + extra);
        set_walk_count(cnt);
        base = $urandom_range(0, VTX_DEPTH - 4);
        sc = $urandom_range(1 << 12, 1 << 22);
        ox = $signed($urandom) >>> 3;
        oy = $signed($urandom) >>> 3;
        oz = $signed($urandom) >>> 3;
        if (full_range)
        begin
            for (int k = 0; k < 4; k++)
                queue_vertex(base + k, $urandom, $urandom, $urandom);
        end
        else
        begin
            queue_vertex(base, ox + $urandom_range(255), oy + $urandom_range(255),
                         oz + $urandom_range(255));
            queue_vertex(base + 1, ox + sc, oy + $urandom_range(255), oz);
            queue_vertex(base + 2, ox, oy + sc, oz + $urandom_range(255));
            queue_vertex(base + 3, ox + $urandom_range(255), oy, oz + sc);
        end
        queue_triangle(0, base, base + 1, base + 2);
        queue_triangle(1, base + 3, base, base + 1);
        queue_triangle(2, base, base + 2, base + 3);
        queue_triangle(3, base + 1, base + 3, base + 2);
        for (int k = 0; k < extra; k++)
            queue_triangle(4 + k, pick_vtx(), pick_vtx(), pick_vtx());
        if ($urandom_range(3) == 0)
            queue_triangle($urandom_range(512, TRI_DEPTH - 1), $urandom, $urandom, $urandom);
        if ($urandom_range(9) == 0)
            queue_raw(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
        for (int k = 0; k < 6; k++)
        begin
            q = $urandom_range(99);
            if (full_range || q < 20)
                queue_query($urandom, $urandom, $urandom);
            else if (q < 70)
                queue_query(ox + sc / 16 + $urandom_range(sc / 4),
                            oy + sc / 16 + $urandom_range(sc / 4),
                            oz + sc / 16 + $urandom_range(sc / 4));
            else
                queue_query(ox - sc / 2 + $urandom_range(2 * sc),
                            oy - sc / 2 + $urandom_range(2 * sc),
                            oz - sc / 2 + $urandom_range(2 * sc));
        end
    endtask

    task automatic directed_cases();
        queue_vertex(0, 10 * U, 0, 0);
        queue_vertex(1, 10 * U, 4 * U, 0);
        queue_vertex(2, 10 * U, 0, 4 * U);
        queue_vertex(3, C_MAX, C_MAX, C_MAX);
        queue_vertex(4, C_MIN, C_MIN, C_MIN);
        queue_vertex(5, 0, 0, 0);
        queue_triangle(0, 0, 1, 2);
        queue_triangle(1, 3, 4, 5);
        queue_triangle(TRI_DEPTH - 1, 1023, 512, 341);
        queue_query(C_MIN, C_MAX, 0);
        set_walk_count(1);
        queue_query(0, U, U);
        queue_query(20 * U, U, U);
        queue_query(0, 10 * U, 10 * U);
        queue_query(0, 0, U);
        queue_raw(REQ_UNUSED, 1023, C_MAX, C_MIN, C_MAX, 1023, 1023, 1023);
        set_walk_count(2);
        queue_query(0, U, U);
        queue_query(C_MAX, C_MAX, C_MAX);
        queue_triangle(0, 5, 5, 5);
        set_walk_count(2047);
        queue_query(U, U, U);
        set_walk_count(1024);
        queue_query(C_MIN, C_MIN, C_MIN);
        queue_query(C_MAX, C_MIN, C_MAX);
    endtask

    initial
    begin
        int send_tab[4];
        int stall_tab[4];
        send_tab = '{0, 51, 0, 30};
        stall_tab = '{0, 0, 51, 30};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 0)
                directed_cases();
            for (int sn = 0; sn < 9; sn++)
                mesh_scene(sn == 0);
        end
        wait_drained();
        repeat (50) @(posedge clk);
        $display("Covered %0d store writes and %0d queries over four idling phases,",
                 n_writes, n_queries);
        $display("walk lengths from 0 to 2047; %0d results checked, %0d mismatches.",
                 n_checked, errors);
        if (errors == 0 && verdict_q.size() == 0)
            $display("point_in_mesh_ray_parity_core_tb passed");
        else
            $display("point_in_mesh_ray_parity_core_tb failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("point_in_mesh_ray_parity_core_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pimr_pkg.sv
rtl/pimr_mac.sv
rtl/pimr_datapath.sv
rtl/pimr_ctrl.sv
rtl/point_in_mesh_ray_parity_core.sv
tb/sv/point_in_mesh_ray_parity_core_tb.sv
